// ----- hw/rtl/klsr_pkg.sv -----
// Package: shared constants, request/result types and control structs of the layer resolver.
`timescale 1ns / 1ps

package klsr_pkg;

  localparam int NumLayers  = 16;
  localparam int NumKeys    = 64;
  localparam int StackDepth = 8;

  localparam int LayerW = 4;
  localparam int KeyW   = 6;
  localparam int IdxW   = $clog2(StackDepth);
  localparam int CntW   = $clog2(StackDepth + 1);
  localparam int TblW   = LayerW + KeyW;
  localparam int TblDepth = NumLayers * NumKeys;

  typedef enum logic [2:0] {
    CmdKey        = 3'd0,
    CmdPushHeld   = 3'd1,
    CmdPushSingle = 3'd2,
    CmdPushExp    = 3'd3,
    CmdSwitch     = 3'd4,
    CmdWrite      = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    KindHeld     = 2'd0,
    KindSingle   = 2'd1,
    KindExpiring = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StUpd,
    StRead,
    StEval,
    StBaseRd,
    StBaseRes,
    StExec
  } state_e;

  typedef struct packed {
    logic [2:0]        command;
    logic [KeyW-1:0]   key_id;
    logic              pressed;
    logic [LayerW-1:0] layer_id;
    logic [31:0]       event_time;
    logic [31:0]       expire_time;
    logic [15:0]       action_in;
  } req_t;

  typedef struct packed {
    logic              has_action;
    logic [15:0]       action_out;
    logic [LayerW-1:0] from_layer;
    logic              from_base;
    logic              status;
  } res_t;

  typedef struct packed {
    logic ld;
    logic clr_step;
    logic key_upd;
    logic rd;
    logic eval;
    logic base_rd;
    logic base_res;
    logic exec;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic is_event;
    logic i_zero;
    logic stop;
  } sts_t;

endpackage

// ----- hw/rtl/klsr_ctrl.sv -----
// Controller: state machine that sequences clearing, key walks and simple commands.
`timescale 1ns / 1ps

module klsr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  klsr_pkg::sts_t sts_i,
  output klsr_pkg::ctl_t ctl_o,
  output logic           busy_o
);

  klsr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= klsr_pkg::StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      klsr_pkg::StClear:   if (sts_i.clr_last) state_d = klsr_pkg::StIdle;
      klsr_pkg::StIdle: begin
        if (start_i) state_d = sts_i.is_event ? klsr_pkg::StUpd : klsr_pkg::StExec;
      end
      klsr_pkg::StUpd:     state_d = klsr_pkg::StRead;
      klsr_pkg::StRead:    state_d = sts_i.i_zero ? klsr_pkg::StBaseRd : klsr_pkg::StEval;
      klsr_pkg::StEval:    state_d = sts_i.stop ? klsr_pkg::StIdle : klsr_pkg::StRead;
      klsr_pkg::StBaseRd:  state_d = klsr_pkg::StBaseRes;
      klsr_pkg::StBaseRes: state_d = klsr_pkg::StIdle;
      klsr_pkg::StExec:    state_d = klsr_pkg::StIdle;
      default:             state_d = klsr_pkg::StIdle;
    endcase
  end

  always_comb begin
    ctl_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      klsr_pkg::StClear:   ctl_o.clr_step = 1'b1;
      klsr_pkg::StIdle: begin
        busy_o   = 1'b0;
        ctl_o.ld = start_i;
      end
      klsr_pkg::StUpd:     ctl_o.key_upd = 1'b1;
      klsr_pkg::StRead:    ctl_o.rd = !sts_i.i_zero;
      klsr_pkg::StEval:    ctl_o.eval = 1'b1;
      klsr_pkg::StBaseRd:  ctl_o.base_rd = 1'b1;
      klsr_pkg::StBaseRes: ctl_o.base_res = 1'b1;
      klsr_pkg::StExec:    ctl_o.exec = 1'b1;
      default:             busy_o = 1'b1;
    endcase
  end

endmodule

// ----- hw/rtl/klsr_dp.sv -----
// Datapath: overlay stack, key state, action table memory and result register.
`timescale 1ns / 1ps

module klsr_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  klsr_pkg::req_t req_i,
  input  klsr_pkg::ctl_t ctl_i,
  output klsr_pkg::sts_t sts_o,
  output klsr_pkg::res_t res_o,
  output logic           done_o
);

  klsr_pkg::req_t req_q;
  klsr_pkg::res_t res_q;
  logic           done_q;

  logic [15:0] tbl_mem [klsr_pkg::TblDepth];
  logic [15:0] tbl_rd_q;
  logic [31:0] kt_mem [klsr_pkg::NumKeys];
  logic [31:0] kt_rd_q;
  logic [klsr_pkg::NumKeys-1:0] down_q;
  logic [klsr_pkg::TblW-1:0]    clr_q;

  logic [klsr_pkg::LayerW-1:0] e_layer  [klsr_pkg::StackDepth];
  logic [1:0]                  e_kind   [klsr_pkg::StackDepth];
  logic [klsr_pkg::KeyW-1:0]   e_key    [klsr_pkg::StackDepth];
  logic [31:0]                 e_start  [klsr_pkg::StackDepth];
  logic [31:0]                 e_expiry [klsr_pkg::StackDepth];
  logic [klsr_pkg::CntW-1:0]   count_q, i_q;
  logic [klsr_pkg::LayerW-1:0] base_q;

  logic [klsr_pkg::CntW-1:0] i_dec;
  logic [klsr_pkg::IdxW-1:0] idx;
  logic                      valid, hit, is_push, full;
  logic [klsr_pkg::IdxW-1:0] widx;

  assign i_dec = i_q - klsr_pkg::CntW'(1);
  assign idx   = i_dec[klsr_pkg::IdxW-1:0];
  assign widx  = count_q[klsr_pkg::IdxW-1:0];
  assign full  = count_q >= klsr_pkg::CntW'(klsr_pkg::StackDepth);
  assign is_push = (req_q.command == klsr_pkg::CmdPushHeld)
                || (req_q.command == klsr_pkg::CmdPushSingle)
                || (req_q.command == klsr_pkg::CmdPushExp);

  always_comb begin
    case (e_kind[idx])
      klsr_pkg::KindHeld:     valid = down_q[e_key[idx]] && (kt_rd_q <= e_start[idx]);
      klsr_pkg::KindSingle:   valid = 1'b1;
      klsr_pkg::KindExpiring: valid = e_expiry[idx] > req_q.event_time;
      default:                valid = 1'b0;
    endcase
  end

  assign hit = valid && (tbl_rd_q != 16'd0);

  assign sts_o.clr_last = clr_q == klsr_pkg::TblW'(klsr_pkg::TblDepth - 1);
  assign sts_o.is_event = req_i.command == klsr_pkg::CmdKey;
  assign sts_o.i_zero   = i_q == '0;
  assign sts_o.stop     = hit;

  // Table memory: clear sweep, writes and one registered read.
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_step) begin
      tbl_mem[clr_q] <= 16'd0;
    end else if (ctl_i.exec && req_q.command == klsr_pkg::CmdWrite) begin
      tbl_mem[{req_q.layer_id, req_q.key_id}] <= req_q.action_in;
    end
    if (ctl_i.base_rd) begin
      tbl_rd_q <= tbl_mem[{base_q, req_q.key_id}];
    end else if (ctl_i.rd) begin
      tbl_rd_q <= tbl_mem[{e_layer[idx], req_q.key_id}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.key_upd && req_q.pressed) begin
      kt_mem[req_q.key_id] <= req_q.event_time;
    end
    if (ctl_i.rd) begin
      kt_rd_q <= kt_mem[e_key[idx]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld) begin
      req_q <= req_i;
    end
  end

  // Stack entries: payload only.
  always_ff @(posedge clk_i) begin
    if (ctl_i.exec && is_push && !full) begin
      e_layer[widx]  <= req_q.layer_id;
      e_kind[widx]   <= req_q.command == klsr_pkg::CmdPushHeld ? klsr_pkg::KindHeld :
                        req_q.command == klsr_pkg::CmdPushSingle ? klsr_pkg::KindSingle :
                        klsr_pkg::KindExpiring;
      e_key[widx]    <= req_q.command == klsr_pkg::CmdPushHeld ? req_q.key_id : '0;
      e_start[widx]  <= req_q.event_time;
      e_expiry[widx] <= req_q.command == klsr_pkg::CmdPushExp ? req_q.expire_time : 32'd0;
    end else if (ctl_i.eval && (!valid || (hit && e_kind[idx] == klsr_pkg::KindSingle))) begin
      for (int j = 0; j < klsr_pkg::StackDepth - 1; j++) begin
        if (j >= int'(idx)) begin
          e_layer[j]  <= e_layer[j+1];
          e_kind[j]   <= e_kind[j+1];
          e_key[j]    <= e_key[j+1];
          e_start[j]  <= e_start[j+1];
          e_expiry[j] <= e_expiry[j+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      down_q  <= '0;
      count_q <= '0;
      i_q     <= '0;
      base_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= ctl_i.exec || ctl_i.base_res || (ctl_i.eval && hit);
      if (ctl_i.clr_step) clr_q <= clr_q + klsr_pkg::TblW'(1);
      if (ctl_i.key_upd) begin
        down_q[req_q.key_id] <= req_q.pressed;
        i_q <= count_q;
      end
      if (ctl_i.eval) begin
        i_q <= i_dec;
        if (!valid || (hit && e_kind[idx] == klsr_pkg::KindSingle)) begin
          count_q <= count_q - klsr_pkg::CntW'(1);
        end
      end
      if (ctl_i.exec) begin
        if (is_push && !full) count_q <= count_q + klsr_pkg::CntW'(1);
        if (req_q.command == klsr_pkg::CmdSwitch) begin
          base_q  <= req_q.layer_id;
          count_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      res_q.has_action <= 1'b0;
      res_q.action_out <= 16'd0;
      res_q.from_layer <= '0;
      res_q.from_base  <= 1'b0;
      res_q.status     <= is_push && full;
    end else if (ctl_i.base_res) begin
      res_q.has_action <= tbl_rd_q != 16'd0;
      res_q.action_out <= tbl_rd_q;
      res_q.from_layer <= tbl_rd_q != 16'd0 ? base_q : '0;
      res_q.from_base  <= tbl_rd_q != 16'd0;
      res_q.status     <= 1'b0;
    end else if (ctl_i.eval && hit) begin
      res_q.has_action <= 1'b1;
      res_q.action_out <= tbl_rd_q;
      res_q.from_layer <= e_layer[idx];
      res_q.from_base  <= 1'b0;
      res_q.status     <= 1'b0;
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

// ----- hw/rtl/key_layer_stack_resolver.sv -----
// Top level: key event to action resolver over a stack of overlay layers.
`timescale 1ns / 1ps

// Usage:
//   Request channel: drive req_i and raise start_i; the request is taken at a
//   rising edge where start_i is high and busy_o is low. Commands are key
//   event, push held / single-use / expiring overlay, switch base, write table.
//   Result channel: res_o is valid for exactly one cycle while done_o is high;
//   the receiver cannot stall, so it must capture the result in that cycle.
//   Sequencing: push, switch, write and unknown commands pass from acceptance
//   through the execute state to done_o. A key event passes the key update,
//   then for each overlay entry visited from the top a read state (table and
//   key-time memory read) and an evaluation state, then, when no overlay
//   answers, a base-layer read and a base-layer result state.
//   Throughput: one request at a time; a new request can be accepted in the
//   cycle done_o is high.
//   Reset: after rst_ni the block sweeps the 1024-entry action table to zero,
//   one entry a cycle, holding busy_o high until the sweep ends.
module key_layer_stack_resolver (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  klsr_pkg::req_t req_i,
  output logic           busy_o,
  output logic           done_o,
  output klsr_pkg::res_t res_o
);

  klsr_pkg::ctl_t ctl;
  klsr_pkg::sts_t sts;

  // Sequence the request through the datapath.
  klsr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy_o (busy_o)
  );

  // Hold the stack, key state and table; produce the result.
  klsr_dp u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .ctl_i (ctl),
    .sts_o (sts),
    .res_o (res_o),
    .done_o(done_o)
  );

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result without work");
  a_base_has: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.from_base |-> res_o.has_action) else $error("base without action");
  a_has_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.has_action |-> res_o.action_out != 16'd0) else $error("zero action");
  a_status_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status |-> !res_o.has_action) else $error("status with action");
`endif

endmodule

// ----- verif/key_layer_stack_resolver_tb.sv -----
// Testbench: random and directed requests against a behavioural predictor of the layer resolver.
`timescale 1ns / 1ps

module key_layer_stack_resolver_tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  klsr_pkg::req_t req_i = '0;
  logic busy_o, done_o;
  klsr_pkg::res_t res_o;

  key_layer_stack_resolver dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .done_o(done_o), .res_o(res_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Predictor state: a private copy of everything the block remembers.
  logic [15:0]                 tbl_m [klsr_pkg::TblDepth];
  logic [klsr_pkg::LayerW-1:0] base_m;
  int                          depth_m;
  logic [klsr_pkg::LayerW-1:0] ov_layer [klsr_pkg::StackDepth];
  klsr_pkg::kind_e             ov_kind  [klsr_pkg::StackDepth];
  logic [klsr_pkg::KeyW-1:0]   ov_key   [klsr_pkg::StackDepth];
  logic [31:0]                 ov_start [klsr_pkg::StackDepth];
  logic [31:0]                 ov_exp   [klsr_pkg::StackDepth];
  logic                        down_m   [klsr_pkg::NumKeys];
  logic [31:0]                 down_t   [klsr_pkg::NumKeys];

  klsr_pkg::req_t pending_q[$];
  klsr_pkg::res_t awaited_q[$];
  int   n_fail = 0;
  int   n_sent = 0;
  int   n_hits = 0;
  int   n_full = 0;
  bit   stim_done = 0;

  function automatic bit overlay_live(int i, logic [31:0] now);
    case (ov_kind[i])
      klsr_pkg::KindHeld:     return down_m[ov_key[i]] && down_t[ov_key[i]] <= ov_start[i];
      klsr_pkg::KindSingle:   return 1'b1;
      klsr_pkg::KindExpiring: return ov_exp[i] > now;
      default:                return 1'b0;
    endcase
  endfunction

  function automatic void drop_overlay(int i);
    for (int j = i; j + 1 < depth_m; j++) begin
      ov_layer[j] = ov_layer[j+1];
      ov_kind[j]  = ov_kind[j+1];
      ov_key[j]   = ov_key[j+1];
      ov_start[j] = ov_start[j+1];
      ov_exp[j]   = ov_exp[j+1];
    end
    depth_m--;
  endfunction

  function automatic klsr_pkg::res_t resolve_request(klsr_pkg::req_t r);
    klsr_pkg::res_t o;
    bit found;
    int i;
    logic [15:0] a;
    o = '0;
    found = 0;
    case (r.command)
      klsr_pkg::CmdKey: begin
        down_m[r.key_id] = r.pressed;
        if (r.pressed) down_t[r.key_id] = r.event_time;
        i = depth_m;
        while (i > 0 && !found) begin
          i--;
          if (!overlay_live(i, r.event_time)) begin
            drop_overlay(i);
          end else begin
            a = tbl_m[{ov_layer[i], r.key_id}];
            if (a != 0) begin
              found = 1;
              o.has_action = 1'b1;
              o.action_out = a;
              o.from_layer = ov_layer[i];
              if (ov_kind[i] == klsr_pkg::KindSingle) drop_overlay(i);
            end
          end
        end
        if (!found) begin
          a = tbl_m[{base_m, r.key_id}];
          if (a != 0) begin
            o.has_action = 1'b1;
            o.action_out = a;
            o.from_layer = base_m;
            o.from_base  = 1'b1;
          end
        end
      end
      klsr_pkg::CmdPushHeld, klsr_pkg::CmdPushSingle, klsr_pkg::CmdPushExp: begin
        if (depth_m >= klsr_pkg::StackDepth) begin
          o.status = 1'b1;
        end else begin
          ov_layer[depth_m] = r.layer_id;
          ov_kind[depth_m]  = (r.command == klsr_pkg::CmdPushHeld) ? klsr_pkg::KindHeld :
                              (r.command == klsr_pkg::CmdPushSingle) ? klsr_pkg::KindSingle :
                              klsr_pkg::KindExpiring;
          ov_key[depth_m]   = (r.command == klsr_pkg::CmdPushHeld) ? r.key_id : '0;
          ov_start[depth_m] = r.event_time;
          ov_exp[depth_m]   = (r.command == klsr_pkg::CmdPushExp) ? r.expire_time : '0;
          depth_m++;
        end
      end
      klsr_pkg::CmdSwitch: begin
        base_m  = r.layer_id;
        depth_m = 0;
      end
      klsr_pkg::CmdWrite: tbl_m[{r.layer_id, r.key_id}] = r.action_in;
      default: ;
    endcase
    return o;
  endfunction

  // Driver: advance on the falling edge; hold start_i high across back-to-back requests.
  int gap_left = 0;
  bit in_flight = 0;
  bit busy_prev = 1;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_flight && !busy_prev) begin
        in_flight = 0;
      end
      if (!in_flight) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          req_i   <= pending_q.pop_front();
          start_i <= 1'b1;
          in_flight = 1;
          gap_left = ($urandom_range(0, 3) == 0) ? 0 :
                     ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
                     $urandom_range(0, 3);
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Acceptance seen at the rising edge; busy_prev tells the driver the request went in.
  always @(posedge clk_i) begin
    busy_prev <= busy_o;
    if (rst_ni && start_i && !busy_o) begin
      awaited_q.push_back(resolve_request(req_i));
      n_sent++;
    end
  end

  // Monitor: compare each strobed result with the oldest prediction.
  always @(posedge clk_i) begin
    klsr_pkg::res_t want;
    if (rst_ni && done_o) begin
      if (awaited_q.size() == 0) begin
        $error("result with nothing awaited");
        n_fail++;
      end else begin
        want = awaited_q.pop_front();
        if (want.has_action) n_hits++;
        if (want.status) n_full++;
        if (res_o.has_action !== want.has_action) begin
          $error("has_action: expected %0d got %0d", want.has_action, res_o.has_action);
          n_fail++;
        end
        if (res_o.action_out !== want.action_out) begin
          $error("action_out: expected %0h got %0h", want.action_out, res_o.action_out);
          n_fail++;
        end
        if (res_o.from_layer !== want.from_layer) begin
          $error("from_layer: expected %0d got %0d", want.from_layer, res_o.from_layer);
          n_fail++;
        end
        if (res_o.from_base !== want.from_base) begin
          $error("from_base: expected %0d got %0d", want.from_base, res_o.from_base);
          n_fail++;
        end
        if (res_o.status !== want.status) begin
          $error("status: expected %0d got %0d", want.status, res_o.status);
          n_fail++;
        end
      end
    end
  end

  function automatic klsr_pkg::req_t mk_req(klsr_pkg::cmd_e c, int key, bit prs, int lay,
                                            logic [31:0] t, logic [31:0] ex,
                                            logic [15:0] act);
    klsr_pkg::req_t r;
    r.command = c;
    r.key_id = klsr_pkg::KeyW'(key);
    r.pressed = prs;
    r.layer_id = klsr_pkg::LayerW'(lay);
    r.event_time = t;
    r.expire_time = ex;
    r.action_in = act;
    return r;
  endfunction

  // Random request: mostly well-formed with a small working set of keys so the stack matters.
  function automatic klsr_pkg::req_t rand_req(ref logic [31:0] clock_us);
    klsr_pkg::req_t r;
    int pick;
    r = '0;
    r.event_time = $urandom;
    r.expire_time = $urandom;
    r.action_in = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
    r.key_id = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
    r.layer_id = 4'($urandom);
    r.pressed = 1'($urandom_range(0, 1));
    clock_us += $urandom_range(1, 200);
    if ($urandom_range(0, 4) != 0) begin
      r.event_time = clock_us;
      r.expire_time = clock_us + $urandom_range(0, 1500);
    end
    pick = $urandom_range(0, 99);
    if (pick < 40)       r.command = klsr_pkg::CmdKey;
    else if (pick < 52)  r.command = klsr_pkg::CmdPushHeld;
    else if (pick < 62)  r.command = klsr_pkg::CmdPushSingle;
    else if (pick < 72)  r.command = klsr_pkg::CmdPushExp;
    else if (pick < 75)  r.command = klsr_pkg::CmdSwitch;
    else if (pick < 97)  r.command = klsr_pkg::CmdWrite;
    else                 r.command = 3'($urandom_range(6, 7));
    return r;
  endfunction

  initial begin
    logic [31:0] clock_us;
    for (int i = 0; i < klsr_pkg::TblDepth; i++) tbl_m[i] = '0;
    for (int k = 0; k < klsr_pkg::NumKeys; k++) begin
      down_m[k] = 1'b0;
      down_t[k] = '0;
    end
    base_m = '0;
    depth_m = 0;

    // Directed: table extremes, every command, full stack refusal, held/expiry invalidation.
    pending_q.push_back(mk_req(klsr_pkg::CmdKey, 0, 1, 0, 32'd5, 0, 0));
    pending_q.push_back(mk_req(klsr_pkg::CmdWrite, 63, 0, 15, 0, 0, 16'hFFFF));
    pending_q.push_back(mk_req(klsr_pkg::CmdWrite, 0, 0, 0, 0, 0, 16'h0001));
    pending_q.push_back(mk_req(klsr_pkg::CmdWrite, 63, 0, 3, 0, 0, 16'h1234));
    pending_q.push_back(mk_req(klsr_pkg::CmdKey, 0, 1, 0, 32'd10, 0, 0));
    pending_q.push_back(mk_req(klsr_pkg::CmdSwitch, 0, 0, 15, 32'd11, 0, 0));
    pending_q.push_back(mk_req(klsr_pkg::CmdKey, 63, 1, 0, 32'hFFFF_FFFF, 0, 0));
    pending_q.push_back(mk_req(klsr_pkg::CmdKey, 63, 0, 0, 32'd20, 0, 0));
    pending_q.push_back(mk_req(klsr_pkg::CmdPushSingle, 0, 0, 3, 32'd21, 0, 0));
    pending_q.push_back(mk_req(klsr_pkg::CmdPushExp, 0, 0, 3, 32'd22, 32'd100, 0));
    pending_q.push_back(mk_req(klsr_pkg::CmdPushHeld, 5, 0, 3, 32'd23, 0, 0));
    pending_q.push_back(mk_req(klsr_pkg::CmdPushHeld, 5, 0, 3, 32'd24, 0, 0));
    for (int i = 0; i < 6; i++)
      pending_q.push_back(mk_req(klsr_pkg::CmdPushExp, 0, 0, 3, 32'd25, 32'hFFFF_FFFF, 0));
    pending_q.push_back(mk_req(klsr_pkg::CmdKey, 63, 1, 0, 32'd200, 0, 0));
    pending_q.push_back(mk_req(klsr_pkg::CmdKey, 63, 1, 0, 32'd300, 0, 0));
    pending_q.push_back(mk_req(klsr_pkg::cmd_e'(3'd6), 63, 1, 15, '1, '1, '1));
    pending_q.push_back(mk_req(klsr_pkg::cmd_e'(3'd7), 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk_req(klsr_pkg::CmdSwitch, 0, 0, 0, 32'd400, 0, 0));

    clock_us = 32'd1000;
    for (int n = 0; n < 1450; n++) pending_q.push_back(rand_req(clock_us));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    wait (pending_q.size() == 0 && !in_flight);
    wait (awaited_q.size() == 0);
    repeat (40) @(posedge clk_i);
    $display("ran %0d requests: %0d key events resolved to an action, %0d pushes refused",
             n_sent, n_hits, n_full);
    if (n_fail == 0 && awaited_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(64'd20 * 64'd400000);
    $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/klsr_pkg.sv
hw/rtl/klsr_ctrl.sv
hw/rtl/klsr_dp.sv
hw/rtl/key_layer_stack_resolver.sv
verif/key_layer_stack_resolver_tb.sv
